[hw/rtl/fraction_reduce_mul_div_assert.svh]
// assertion macros for the fraction unit checker
`ifndef FRACTION_REDUCE_MUL_DIV_ASSERT_SVH
`define FRACTION_REDUCE_MUL_DIV_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define FRM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/frm_pkg.sv]
// package: widths, action codes, divider operand sources and controller/datapath bundles of the fraction unit
`timescale 1ns / 1ps
`default_nettype none
package frm_pkg;

    localparam int DataWidth = 32;
    localparam int ResWidth  = 64;

    // action codes
    localparam logic [1:0] ActReduce = 2'd0;
    localparam logic [1:0] ActMul    = 2'd1;
    localparam logic [1:0] ActDiv    = 2'd2;

    // divider operand sources
    localparam logic [1:0] SrcEuclid = 2'd0;
    localparam logic [1:0] SrcQuoNum = 2'd1;
    localparam logic [1:0] SrcQuoDen = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_src;
        logic       euc_update;
        logic       store_qn;
        logic       store_qd;
        logic       mul_num;
        logic       mul_den;
        logic       set_zero;
        logic       set_err;
    } t_ctrl_cmd;

    typedef struct packed {
        logic       x_zero;
        logic       y_zero;
        logic       div_busy;
        logic [1:0] action;
    } t_dp_stat;

endpackage
`default_nettype wire

[hw/rtl/frm_if.sv]
// item channel interfaces: input fractions and result
`timescale 1ns / 1ps
`default_nettype none
interface frm_in_if import frm_pkg::*; #(
    parameter int DW = DataWidth
) ();
    logic          valid;
    logic          ready;
    logic [1:0]    action;
    logic [DW-1:0] a_num;
    logic [DW-1:0] a_den;
    logic [DW-1:0] b_num;
    logic [DW-1:0] b_den;

    modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface frm_out_if import frm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ResWidth-1:0] res_num;
    logic [ResWidth-1:0] res_den;
    logic                div_error;

    modport source (output valid, res_num, res_den, div_error, input ready);
    modport sink   (input valid, res_num, res_den, div_error, output ready);
endinterface
`default_nettype wire

[hw/rtl/frm_datapath.sv]
// datapath: operand registers, bit-serial divider, shared multiplier, result registers
`timescale 1ns / 1ps
`default_nettype none
module frm_datapath import frm_pkg::*; #(
    parameter int DATA_WIDTH = DataWidth
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl_cmd             i_cmd,
    input  wire logic [1:0]            i_action,
    input  wire logic [DATA_WIDTH-1:0] i_a_num,
    input  wire logic [DATA_WIDTH-1:0] i_a_den,
    input  wire logic [DATA_WIDTH-1:0] i_b_num,
    input  wire logic [DATA_WIDTH-1:0] i_b_den,
    output t_dp_stat                   o_stat,
    output logic [ResWidth-1:0]        o_res_num,
    output logic [ResWidth-1:0]        o_res_den,
    output logic                       o_div_error
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [1:0]             r_action;
    logic signed [W-1:0]    r_an, r_ad, r_bn, r_bd, r_x, r_y;
    logic [ResWidth-1:0]    r_rn, r_rd;
    logic                   r_err;

    logic [W-1:0]           r_rem, r_quo, r_dvsr;
    logic                   r_dnd_neg, r_q_neg;
    logic [CW-1:0]          r_cnt;

    logic signed [W-1:0]    dnd, dvs;
    logic [W-1:0]           dnd_mag, dvs_mag;
    logic [W:0]             trial, diff;
    logic                   ge;
    logic signed [W-1:0]    rem_s;
    logic [ResWidth-1:0]    quo_ext, quo_s;
    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [2*W-1:0]  prod;

    // divider operand select
    always_comb begin
        case (i_cmd.div_src)
            SrcQuoNum: begin dnd = r_an; dvs = r_x; end
            SrcQuoDen: begin dnd = r_ad; dvs = r_x; end
            default:   begin dnd = r_x;  dvs = r_y; end
        endcase
        dnd_mag = dnd[W-1] ? W'(-dnd) : dnd;
        dvs_mag = dvs[W-1] ? W'(-dvs) : dvs;
    end

    // one restoring step on magnitudes
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvsr};
    assign ge    = ~diff[W];

    // truncating signs: remainder follows dividend, quotient the sign product
    assign rem_s   = r_dnd_neg ? W'(-$signed(r_rem)) : $signed(r_rem);
    assign quo_ext = ResWidth'(r_quo);
    assign quo_s   = r_q_neg ? ResWidth'(-quo_ext) : quo_ext;

    // shared multiplier, operands by action
    always_comb begin
        mul_a = i_cmd.mul_num ? r_an : r_ad;
        if (i_cmd.mul_num) begin
            mul_b = (r_action == ActMul) ? r_bn : r_bd;
        end else begin
            mul_b = (r_action == ActMul) ? r_bd : r_bn;
        end
        prod = mul_a * mul_b;
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= dnd_mag;
            r_dvsr    <= dvs_mag;
            r_dnd_neg <= dnd[W-1];
            r_q_neg   <= dnd[W-1] ^ dvs[W-1];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    // operand and euclid registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_an     <= i_a_num;
            r_ad     <= i_a_den;
            r_bn     <= i_b_num;
            r_bd     <= i_b_den;
            r_x      <= i_a_num;
            r_y      <= i_a_den;
        end else if (i_cmd.euc_update) begin
            r_x <= r_y;
            r_y <= rem_s;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= 1'b0;
        end else if (i_cmd.set_zero) begin
            r_rn  <= '0;
            r_rd  <= '0;
            r_err <= i_cmd.set_err;
        end else begin
            if (i_cmd.store_qn) r_rn <= quo_s;
            if (i_cmd.store_qd) r_rd <= quo_s;
            if (i_cmd.mul_num)  r_rn <= ResWidth'(prod);
            if (i_cmd.mul_den)  r_rd <= ResWidth'(prod);
        end
    end

    assign o_stat.x_zero   = (r_x == '0);
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.div_busy = (r_cnt != '0);
    assign o_stat.action   = r_action;
    assign o_res_num       = r_rn;
    assign o_res_den       = r_rd;
    assign o_div_error     = r_err;
endmodule
`default_nettype wire

[hw/rtl/frm_ctrl.sv]
// controller: sequences euclid steps, quotients and products for one item
`timescale 1ns / 1ps
`default_nettype none
module frm_ctrl import frm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_ctrl_cmd     o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ECHK = 4'd2;
    localparam logic [3:0] S_EDIV = 4'd3;
    localparam logic [3:0] S_QN   = 4'd4;
    localparam logic [3:0] S_QD   = 4'd5;
    localparam logic [3:0] S_MUL1 = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.action)
                    ActReduce: n_state = S_ECHK;
                    ActMul, ActDiv: n_state = S_MUL1;
                    default: begin
                        o_cmd.set_zero = 1'b1;
                        n_state        = S_OUT;
                    end
                endcase
            end
            // euclid loop: stop once the divisor is zero
            S_ECHK: begin
                if (i_stat.y_zero) begin
                    if (i_stat.x_zero) begin
                        o_cmd.set_zero = 1'b1;
                        o_cmd.set_err  = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_src   = SrcQuoNum;
                        n_state         = S_QN;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = SrcEuclid;
                    n_state         = S_EDIV;
                end
            end
            S_EDIV: begin
                o_cmd.div_src = SrcEuclid;
                if (!i_stat.div_busy) begin
                    o_cmd.euc_update = 1'b1;
                    n_state          = S_ECHK;
                end
            end
            S_QN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.store_qn  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = SrcQuoDen;
                    n_state         = S_QD;
                end
            end
            S_QD: begin
                if (!i_stat.div_busy) begin
                    o_cmd.store_qd = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_MUL1: begin
                o_cmd.mul_num = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_den = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/fraction_reduce_mul_div.sv]
// Fraction unit: reduces a/b by gcd (truncating Euclid, so a negative gcd flips both
// signs; both zero gives div_error with a 0/0 result), or forms the unreduced 64-bit
// products for multiply and divide; action code 3 returns 0/0. One item is in flight
// at a time and the input is not ready until the result has been taken. Multiply and
// divide pass through a dispatch state and then the numerator and denominator multiply
// states before the result is valid. Reduce time is set by the bit-serial divider, one
// quotient bit per cycle, which runs once per euclid remainder step and then once each
// for the two quotients, with at most about 45 euclid steps for 32-bit operands.
`timescale 1ns / 1ps
`default_nettype none
module fraction_reduce_mul_div import frm_pkg::*; #(
    parameter int DATA_WIDTH = DataWidth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    frm_in_if.sink     i_item,
    frm_out_if.source  o_item
);
    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencing
    frm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_item.valid),
        .i_out_ready (o_item.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic
    frm_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_item.action),
        .i_a_num     (i_item.a_num),
        .i_a_den     (i_item.a_den),
        .i_b_num     (i_item.b_num),
        .i_b_den     (i_item.b_den),
        .o_stat      (stat),
        .o_res_num   (o_item.res_num),
        .o_res_den   (o_item.res_den),
        .o_div_error (o_item.div_error)
    );
endmodule
`default_nettype wire

[hw/rtl/frm_checker.sv]
// port checker for the fraction unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "fraction_reduce_mul_div_assert.svh"
module frm_checker import frm_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [ResWidth-1:0] i_res_num,
    input wire logic [ResWidth-1:0] i_res_den,
    input wire logic                i_div_error
);
    // one item at a time: no input taken while a result waits
    `FRM_ASSERT_IMPL(a_no_overlap, i_out_valid, !i_in_ready, "input ready while result pending")
    // no result is valid in the cycle after an item is accepted
    `FRM_ASSERT_NEXT(a_no_instant, i_in_valid && i_in_ready, !i_out_valid, "result right after accept")
    // error results carry 0/0
    `FRM_ASSERT_IMPL(a_err_zero, i_out_valid && i_div_error,
        i_res_num == '0 && i_res_den == '0, "error result not 0/0")
    // a stalled result holds
    `FRM_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_res_num) && $stable(i_res_den), "stalled result changed")
endmodule

bind fraction_reduce_mul_div frm_checker u_frm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_res_num   (o_item.res_num),
    .i_res_den   (o_item.res_den),
    .i_div_error (o_item.div_error)
);
`default_nettype wire

[test/tb_fraction_reduce_mul_div.sv]
// testbench: fraction unit checked against a gcd and product predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_fraction_reduce_mul_div;
    import frm_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_frac_in;

    typedef struct packed {
        logic [63:0] res_num;
        logic [63:0] res_den;
        logic        div_error;
    } t_frac_res;

    // directed row: item plus optional typed-in result
    typedef struct packed {
        t_frac_in  item;
        logic      fixed;
        t_frac_res res;
    } t_row;

    localparam logic [1:0] ActUnused = 2'd3;
    localparam int CycleLimit = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;
    longint cycles;

    frm_in_if  i_item ();
    frm_out_if o_item ();

    fraction_reduce_mul_div i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_item.sink),
        .o_item (o_item.source)
    );

    t_frac_res results_due[$];
    t_row      rows[$];

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("fraction_reduce_mul_div test failed");
            $finish;
        end
    end

    function automatic longint trunc_gcd(longint x, longint y);
        longint r;
        while (y != 0) begin
            r = (y == -1) ? 0 : x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_frac_res fraction_result(t_frac_in it);
        t_frac_res r;
        longint an, ad, bn, bd, g;
        an = longint'(signed'(it.a_num));
        ad = longint'(signed'(it.a_den));
        bn = longint'(signed'(it.b_num));
        bd = longint'(signed'(it.b_den));
        r = '0;
        case (it.action)
            ActReduce: begin
                g = trunc_gcd(an, ad);
                if (g == 0) begin
                    r.div_error = 1'b1;
                end else begin
                    r.res_num = an / g;
                    r.res_den = ad / g;
                end
            end
            ActMul: begin
                r.res_num = an * bn;
                r.res_den = ad * bd;
            end
            ActDiv: begin
                r.res_num = an * bd;
                r.res_den = ad * bn;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report(string what, t_frac_res got, t_frac_res want);
        n_errors++;
        $display("mismatch %s: got %0d/%0d err %0b, want %0d/%0d err %0b", what,
                 $signed(got.res_num), $signed(got.res_den), got.div_error,
                 $signed(want.res_num), $signed(want.res_den), want.div_error);
    endtask

    // send one item after a random gap, valid drops only while idling
    task automatic send_item(t_frac_in it, bit fixed, t_frac_res res);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_item.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item.valid  <= 1'b1;
        i_item.action <= it.action;
        i_item.a_num  <= it.a_num;
        i_item.a_den  <= it.a_den;
        i_item.b_num  <= it.b_num;
        i_item.b_den  <= it.b_den;
        @(posedge i_clk);
        while (!i_item.ready) @(posedge i_clk);
        results_due.push_back(fixed ? res : fraction_result(it));
    endtask

    // result side: random stalls, compare with oldest expectation
    initial begin
        int stall;
        t_frac_res got, want;
        o_item.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                o_item.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            o_item.ready <= 1'b1;
            @(posedge i_clk);
            while (!o_item.valid) @(posedge i_clk);
            got = {o_item.res_num, o_item.res_den, o_item.div_error};
            if (results_due.size() == 0) begin
                report("unexpected item", got, '0);
            end else begin
                want = results_due.pop_front();
                if (got.res_num !== want.res_num) report("res_num", got, want);
                if (got.res_den !== want.res_den) report("res_den", got, want);
                if (got.div_error !== want.div_error) report("div_error", got, want);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return $urandom_range(0, 2000) * (1 + $urandom_range(0, 300));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row row(logic [1:0] act, int an, int ad, int bn, int bd,
                                 logic fixed, longint rn, longint rd, logic err);
        t_row r;
        r.item  = '{act, an, ad, bn, bd};
        r.fixed = fixed;
        r.res   = '{rn, rd, err};
        return r;
    endfunction

    initial begin
        t_frac_in it;
        int       k, mult;
        n_errors = 0;
        cycles   = 0;
        i_rst_n  = 1'b0;
        i_item.valid  = 1'b0;
        i_item.action = ActReduce;
        i_item.a_num  = '0;
        i_item.a_den  = '0;
        i_item.b_num  = '0;
        i_item.b_den  = '0;

        // directed items
        rows.push_back(row(ActReduce, 0, 0, 0, 0, 1, 0, 0, 1));
        rows.push_back(row(ActReduce, 5, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(row(ActReduce, -5, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(row(ActReduce, 0, 7, 0, 0, 1, 0, 1, 0));
        rows.push_back(row(ActReduce, 32'h8000_0000, -1, 0, 0, 1,
                           64'sd2147483648, 1, 0));
        rows.push_back(row(ActReduce, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 1, 1, 0));
        rows.push_back(row(ActReduce, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(ActReduce, 12, -18, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(ActReduce, -12, 18, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(ActReduce, 1836311903, 1134903170, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(ActMul, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 1,
                           64'sh4000_0000_0000_0000, 64'sh4000_0000_0000_0000, 0));
        rows.push_back(row(ActMul, 32'h7fff_ffff, -1, 32'h8000_0000, 0, 0, 0, 0, 0));
        rows.push_back(row(ActDiv, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 0, 0, 0, 0));
        rows.push_back(row(ActDiv, 3, 4, 0, -5, 0, 0, 0, 0));
        rows.push_back(row(ActUnused, -1, -1, -1, -1, 1, 0, 0, 0));
        rows.push_back(row(ActUnused, 9, 3, 2, 1, 1, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);

        // random items, about half of them reduce, some with shared factors so gcds are nontrivial
        for (k = 0; k < 360; k++) begin
            it.action = $urandom_range(0, 9) < 5 ? ActReduce : 2'($urandom_range(1, 3));
            it.a_num  = rand_word();
            it.a_den  = rand_word();
            it.b_num  = rand_word();
            it.b_den  = rand_word();
            if (it.action == ActReduce && $urandom_range(0, 1)) begin
                mult     = $urandom_range(1, 5000);
                it.a_num = $signed(it.a_num[15:0]) * mult;
                it.a_den = $signed(it.a_den[15:0]) * mult;
            end
            if (k == 180) begin
                // hold off until everything is back
                i_item.valid <= 1'b0;
                while (results_due.size() != 0) @(posedge i_clk);
            end
            send_item(it, 1'b0, '0);
        end
        i_item.valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2000) begin
            @(posedge i_clk);
        end
        if (n_errors == 0) begin
            $display("fraction_reduce_mul_div test passed");
        end else begin
            $display("fraction_reduce_mul_div test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/frm_pkg.sv
hw/rtl/frm_if.sv
hw/rtl/frm_datapath.sv
hw/rtl/frm_ctrl.sv
hw/rtl/fraction_reduce_mul_div.sv
hw/rtl/frm_checker.sv
test/tb_fraction_reduce_mul_div.sv
